### rtl/tsrt_pkg.sv
// Package: constants, result codes, FSM state type, slot record and sequence helpers for the reassembly tracker.
`timescale 1ns / 1ps
package tsrt_pkg;
    localparam int SLOTS      = 8;
    localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_BITS   = 7;
    localparam int LEN_BITS   = 16;

    typedef enum logic [2:0] {
        KIND_DELIVER_IN   = 3'd0,
        KIND_DELIVER_SLOT = 3'd1,
        KIND_BUFFERED     = 3'd2,
        KIND_DUPLICATE    = 3'd3,
        KIND_OVERLAP      = 3'd4,
        KIND_FULL         = 3'd5,
        KIND_EMPTY        = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_EMIT,
        ST_FLUSH_RD,
        ST_FLUSH_CHK,
        ST_FLUSH_HIT,
        ST_FLUSH_END
    } state_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] len;
        logic [15:0] tag;
    } slot_t;

    // Modulo 2^32 test: a lies before b.
    function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    // Test s within [lo, hi) with wraparound.
    function automatic logic seq_in_range(input logic [31:0] s, input logic [31:0] lo,
                                          input logic [31:0] hi);
        if (lo <= hi)
            return (s >= lo) && (s < hi);
        return (s >= lo) || (s < hi);
    endfunction
endpackage

### rtl/tcp_segment_reassembly_tracker_top.sv
// Top level: segment classifier, slot table memory and result register.
`timescale 1ns / 1ps
// One segment is handled at a time; a segment is taken in IDLE once the
// output register is free. The slot table sits in a synchronous memory read
// one slot per cycle. Empty and duplicate segments load their single result
// at the accepting edge, and the tracker stays in IDLE. A later segment
// passes through SCAN (the first read), CHECK for each slot in turn and EMIT,
// which loads its result once the output register is free. An in-order
// segment holds its delivery beat while the table is scanned (FLUSH_RD, then
// FLUSH_CHK for each slot, stopping at the first match); each match passes
// through FLUSH_HIT to emit the held beat, release the slot and rescan, and
// the final scan that finds nothing checks all slots and passes through
// FLUSH_END for the last beat. Writing the start sequence register (address
// 0) resets the expected sequence and empties the table at once through
// per-slot valid bits.
module tcp_segment_reassembly_tracker_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] seg_seq,
    input  logic [15:0] seg_len,
    input  logic [15:0] seg_tag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  result_kind,
    output logic [15:0] out_tag,
    output logic [31:0] deliver_seq,
    output logic [15:0] trim_offset,
    output logic [15:0] deliver_len,
    output logic [31:0] exp_after,
    output logic [6:0]  buffered_count,
    output logic        last
);
    localparam int SB = tsrt_pkg::SLOT_BITS;
    localparam int CB = tsrt_pkg::CNT_BITS;

    tsrt_pkg::state_t state_reg, state_next;

    tsrt_pkg::slot_t mem [tsrt_pkg::SLOTS];
    tsrt_pkg::slot_t rd_data_reg;
    logic [SB-1:0]   rd_addr;
    logic            mem_we;
    logic [SB-1:0]   wr_addr;
    logic [tsrt_pkg::SLOTS-1:0] valid_reg, valid_next;

    logic [31:0] init_reg, exp_reg, exp_next;
    logic [31:0] seq_reg;
    logic [15:0] len_reg, tag_reg, ptrim_reg;
    logic [SB:0] idx_reg, idx_next;       // scan counter, can hold SLOTS
    logic [SB:0] ridx_reg;                // slot index of data in rd_data_reg
    logic        clash_reg, clash_next;
    logic        free_found_reg, free_found_next;
    logic [SB-1:0] free_reg, free_next;
    logic        chain_reg, chain_next;   // held beat is a chain release
    logic [CB-1:0] count_reg;

    // Slot data of a found chain entry
    logic [31:0]   hseq_reg;
    logic [15:0]   hlen_reg, htag_reg;
    logic [SB-1:0] hidx_reg;

    logic        ov_reg;
    logic [2:0]  kind_reg;
    logic [15:0] otag_reg, trim_reg, dlen_reg;
    logic [31:0] dseq_reg;
    logic        last_reg;
    logic        load_out;
    logic [2:0]  o_kind;
    logic [15:0] o_tag, o_trim, o_dlen;
    logic [31:0] o_dseq;
    logic        o_last;
    logic [CB-1:0] o_cnt;
    logic [CB-1:0] count_next;
    logic        cfg_wr;

    logic [31:0] nexp_reg;
    logic [CB-1:0] ncnt_reg;

    logic [15:0] len_m, d_trim, d_len;
    logic [31:0] seg_end, trim_w, slot_end;
    logic        is_old, is_exact, dup;
    logic        out_free;
    logic        flush_hit;

    assign pready = 1'b1;
    assign prdata = init_reg;
    assign cfg_wr = psel && penable && pwrite && (paddr == 1'b0);
    assign out_free = !ov_reg || out_ready;

    assign len_m    = 16'(seg_len[tsrt_pkg::LEN_BITS-1:0]);
    assign seg_end  = seg_seq + {16'd0, len_m};
    assign is_exact = (seg_seq == exp_reg);
    assign is_old   = tsrt_pkg::seq_before(seg_seq, exp_reg);
    assign trim_w   = exp_reg - seg_seq;
    assign dup      = !is_exact && (tsrt_pkg::seq_before(seg_end, exp_reg) ||
                      (seg_end == exp_reg) || (trim_w >= {16'd0, len_m}));
    assign d_trim   = is_exact ? 16'd0 : trim_w[15:0];
    assign d_len    = len_m - d_trim;
    assign slot_end = rd_data_reg.seq + {16'd0, rd_data_reg.len};
    assign flush_hit = valid_reg[ridx_reg[SB-1:0]] && (rd_data_reg.seq == exp_reg);

    assign in_ready = (state_reg == tsrt_pkg::ST_IDLE) && out_free;

    // Slot table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= '{seq: seq_reg, len: len_reg, tag: tag_reg};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_addr = idx_reg[SB-1:0];
    assign wr_addr = free_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsrt_pkg::ST_IDLE:
                if (in_valid && in_ready && len_m != '0 && !is_exact && !is_old)
                    state_next = tsrt_pkg::ST_SCAN;
                else if (in_valid && in_ready && len_m != '0 && (is_exact || !dup))
                    state_next = tsrt_pkg::ST_FLUSH_RD;
            tsrt_pkg::ST_SCAN:
                state_next = tsrt_pkg::ST_CHECK;
            tsrt_pkg::ST_CHECK:
                if (ridx_reg == (SB+1)'(tsrt_pkg::SLOTS - 1))
                    state_next = tsrt_pkg::ST_EMIT;
            tsrt_pkg::ST_EMIT:
                if (out_free)
                    state_next = tsrt_pkg::ST_IDLE;
            tsrt_pkg::ST_FLUSH_RD:
                state_next = tsrt_pkg::ST_FLUSH_CHK;
            tsrt_pkg::ST_FLUSH_CHK:
                if (flush_hit)
                    state_next = tsrt_pkg::ST_FLUSH_HIT;
                else if (ridx_reg == (SB+1)'(tsrt_pkg::SLOTS - 1))
                    state_next = tsrt_pkg::ST_FLUSH_END;
            tsrt_pkg::ST_FLUSH_HIT:
                if (out_free)
                    state_next = tsrt_pkg::ST_FLUSH_RD;
            tsrt_pkg::ST_FLUSH_END:
                if (out_free)
                    state_next = tsrt_pkg::ST_IDLE;
            default:
                state_next = tsrt_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        exp_next        = exp_reg;
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        clash_next      = clash_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        chain_next      = chain_reg;
        count_next      = count_reg;
        mem_we          = 1'b0;
        load_out        = 1'b0;
        o_kind          = tsrt_pkg::KIND_EMPTY;
        o_tag           = tag_reg;
        o_dseq          = seq_reg;
        o_trim          = '0;
        o_dlen          = '0;
        o_last          = 1'b1;
        o_cnt           = count_reg;
        unique case (state_reg)
            tsrt_pkg::ST_IDLE:
            begin
                idx_next        = '0;
                clash_next      = 1'b0;
                free_found_next = 1'b0;
                chain_next      = 1'b0;
                if (in_valid && in_ready)
                begin
                    o_tag  = seg_tag;
                    o_dseq = seg_seq;
                    if (len_m == '0)
                    begin
                        load_out = 1'b1;
                    end
                    else if (is_exact || is_old)
                    begin
                        if (dup)
                        begin
                            load_out = 1'b1;
                            o_kind   = tsrt_pkg::KIND_DUPLICATE;
                        end
                        else
                        begin
                            // advance past the delivered bytes; hold the beat for the scan
                            exp_next = exp_reg + {16'd0, d_len};
                        end
                    end
                end
            end
            tsrt_pkg::ST_SCAN:
            begin
                idx_next = idx_reg + (SB+1)'(1);
            end
            tsrt_pkg::ST_CHECK:
            begin
                if (idx_reg < (SB+1)'(tsrt_pkg::SLOTS))
                    idx_next = idx_reg + (SB+1)'(1);
                if (valid_reg[ridx_reg[SB-1:0]])
                begin
                    if (tsrt_pkg::seq_in_range(seq_reg, rd_data_reg.seq, slot_end) ||
                        tsrt_pkg::seq_in_range(rd_data_reg.seq, seq_reg,
                                               seq_reg + {16'd0, len_reg}))
                        clash_next = 1'b1;
                end
                else if (!free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_next       = ridx_reg[SB-1:0];
                end
            end
            tsrt_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (clash_reg)
                        o_kind = tsrt_pkg::KIND_OVERLAP;
                    else if (!free_found_reg)
                        o_kind = tsrt_pkg::KIND_FULL;
                    else
                    begin
                        o_kind     = tsrt_pkg::KIND_BUFFERED;
                        mem_we     = 1'b1;
                        valid_next[free_reg] = 1'b1;
                        count_next = count_reg + CB'(1);
                        o_cnt      = count_reg + CB'(1);
                    end
                end
            end
            tsrt_pkg::ST_FLUSH_RD:
            begin
                idx_next = (SB+1)'(1);
            end
            tsrt_pkg::ST_FLUSH_CHK:
            begin
                if (!flush_hit && idx_reg < (SB+1)'(tsrt_pkg::SLOTS))
                    idx_next = idx_reg + (SB+1)'(1);
            end
            tsrt_pkg::ST_FLUSH_HIT:
            begin
                // emit the held beat, release the found slot and rescan
                if (out_free)
                begin
                    load_out   = 1'b1;
                    o_kind     = chain_reg ? tsrt_pkg::KIND_DELIVER_SLOT :
                                             tsrt_pkg::KIND_DELIVER_IN;
                    o_trim     = ptrim_reg;
                    o_dlen     = len_reg;
                    o_last     = 1'b0;
                    valid_next[hidx_reg] = 1'b0;
                    count_next = count_reg - CB'(1);
                    exp_next   = hseq_reg + {16'd0, hlen_reg};
                    chain_next = 1'b1;
                    idx_next   = '0;
                end
            end
            tsrt_pkg::ST_FLUSH_END:
            begin
                // nothing more lines up: the held beat closes the segment
                if (out_free)
                begin
                    load_out = 1'b1;
                    o_kind   = chain_reg ? tsrt_pkg::KIND_DELIVER_SLOT :
                                           tsrt_pkg::KIND_DELIVER_IN;
                    o_trim   = ptrim_reg;
                    o_dlen   = len_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Segment, held-beat and result registers
    always_ff @(posedge clk)
    begin
        if (state_reg == tsrt_pkg::ST_IDLE && in_valid && in_ready)
        begin
            if (is_exact || is_old)
            begin
                seq_reg   <= exp_reg;
                len_reg   <= d_len;
                ptrim_reg <= d_trim;
            end
            else
            begin
                seq_reg   <= seg_seq;
                len_reg   <= len_m;
                ptrim_reg <= '0;
            end
            tag_reg <= seg_tag;
        end
        else if (state_reg == tsrt_pkg::ST_FLUSH_HIT && out_free)
        begin
            seq_reg   <= hseq_reg;
            len_reg   <= hlen_reg;
            tag_reg   <= htag_reg;
            ptrim_reg <= '0;
        end
        if (state_reg == tsrt_pkg::ST_FLUSH_CHK && flush_hit)
        begin
            hseq_reg <= rd_data_reg.seq;
            hlen_reg <= rd_data_reg.len;
            htag_reg <= rd_data_reg.tag;
            hidx_reg <= ridx_reg[SB-1:0];
        end
        if (load_out)
        begin
            kind_reg <= o_kind;
            otag_reg <= o_tag;
            dseq_reg <= o_dseq;
            trim_reg <= o_trim;
            dlen_reg <= o_dlen;
            last_reg <= o_last;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tsrt_pkg::ST_IDLE;
            init_reg       <= '0;
            exp_reg        <= '0;
            valid_reg      <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            ridx_reg       <= '0;
            clash_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            free_reg       <= '0;
            chain_reg      <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            ridx_reg       <= idx_reg;
            clash_reg      <= clash_next;
            free_found_reg <= free_found_next;
            free_reg       <= free_next;
            chain_reg      <= chain_next;
            if (cfg_wr)
            begin
                init_reg  <= pwdata;
                exp_reg   <= pwdata;
                valid_reg <= '0;
                count_reg <= '0;
            end
            else
            begin
                exp_reg   <= exp_next;
                valid_reg <= valid_next;
                count_reg <= count_next;
            end
            if (load_out)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // Snapshot of expected and count after each result
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            nexp_reg <= exp_reg;
            ncnt_reg <= o_cnt;
        end
    end

    assign out_valid      = ov_reg;
    assign result_kind    = kind_reg;
    assign out_tag        = otag_reg;
    assign deliver_seq    = dseq_reg;
    assign trim_offset    = trim_reg;
    assign deliver_len    = dlen_reg;
    assign exp_after      = nexp_reg;
    assign buffered_count = ncnt_reg;
    assign last           = last_reg;

    // Checks
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CB'($countones(valid_reg)))
        else $error("slot count mismatch");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == tsrt_pkg::ST_IDLE)
        else $error("accept outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg && $stable(kind_reg))
        else $error("result beat dropped");
endmodule

### bench/tb.sv
// Testbench for the TCP segment reassembly tracker: directed and random segment streams.
`timescale 1ns / 1ps
module tb;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        tsrt_pkg::kind_t kind;
        logic [15:0] tag;
        logic [31:0] dseq;
        logic [15:0] trim;
        logic [15:0] dlen;
        logic [31:0] nexp;
        logic [6:0]  count;
        logic        last;
    } seg_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] seg_seq;
    logic [15:0] seg_len;
    logic [15:0] seg_tag;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  result_kind;
    logic [15:0] out_tag;
    logic [31:0] deliver_seq;
    logic [15:0] trim_offset;
    logic [15:0] deliver_len;
    logic [31:0] exp_after;
    logic [6:0]  buffered_count;
    logic        last;

    // Tracker shadow state
    logic [31:0] trk_expected;
    logic        trk_valid [tsrt_pkg::SLOTS];
    logic [31:0] trk_seq [tsrt_pkg::SLOTS];
    logic [15:0] trk_len [tsrt_pkg::SLOTS];
    logic [15:0] trk_tag [tsrt_pkg::SLOTS];

    seg_result_t pending_results[$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    bit          no_idle;

    tcp_segment_reassembly_tracker_top uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Modulo 2^32 ordering
    function automatic logic seq_lags(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic seq_within(logic [31:0] s, logic [31:0] lo, logic [31:0] hi);
        if (lo <= hi)
            return (s >= lo) && (s < hi);
        return (s >= lo) || (s < hi);
    endfunction

    function automatic logic [6:0] slots_used();
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < tsrt_pkg::SLOTS; i++)
            if (trk_valid[i])
                n++;
        return n;
    endfunction

    function automatic void push_result(tsrt_pkg::kind_t k, logic [15:0] tg, logic [31:0] ds,
                                        logic [15:0] tr, logic [15:0] dl);
        seg_result_t r;
        r.kind  = k;
        r.tag   = tg;
        r.dseq  = ds;
        r.trim  = tr;
        r.dlen  = dl;
        r.nexp  = trk_expected;
        r.count = slots_used();
        r.last  = 1'b0;
        pending_results.push_back(r);
    endfunction

    function automatic void restart_stream(logic [31:0] start);
        trk_expected = start;
        for (int i = 0; i < tsrt_pkg::SLOTS; i++)
            trk_valid[i] = 1'b0;
    endfunction

    // Classify one segment and queue every result it causes
    function automatic void predict_segment(logic [31:0] sq, logic [15:0] ln, logic [15:0] tg);
        logic [31:0] seg_end;
        logic [31:0] slot_end;
        logic [31:0] trim;
        logic        clash;
        logic        found;
        int          free_idx;
        int          emitted;
        seg_result_t r;
        seg_end = sq + {16'd0, ln};
        trim    = '0;
        emitted = 0;
        if (ln == 16'd0) begin
            push_result(tsrt_pkg::KIND_EMPTY, tg, sq, 16'd0, 16'd0);
        end else if (sq != trk_expected && !seq_lags(sq, trk_expected)) begin
            clash    = 1'b0;
            free_idx = -1;
            for (int i = 0; i < tsrt_pkg::SLOTS; i++) begin
                if (!trk_valid[i]) begin
                    if (free_idx < 0)
                        free_idx = i;
                end else begin
                    slot_end = trk_seq[i] + {16'd0, trk_len[i]};
                    if (seq_within(sq, trk_seq[i], slot_end) ||
                        seq_within(trk_seq[i], sq, seg_end))
                        clash = 1'b1;
                end
            end
            if (clash)
                push_result(tsrt_pkg::KIND_OVERLAP, tg, sq, 16'd0, 16'd0);
            else if (free_idx < 0)
                push_result(tsrt_pkg::KIND_FULL, tg, sq, 16'd0, 16'd0);
            else begin
                trk_valid[free_idx] = 1'b1;
                trk_seq[free_idx]   = sq;
                trk_len[free_idx]   = ln;
                trk_tag[free_idx]   = tg;
                push_result(tsrt_pkg::KIND_BUFFERED, tg, sq, 16'd0, 16'd0);
            end
        end else begin
            if (sq != trk_expected)
                trim = trk_expected - sq;
            if (sq != trk_expected && (seq_lags(seg_end, trk_expected) ||
                seg_end == trk_expected || trim >= {16'd0, ln})) begin
                push_result(tsrt_pkg::KIND_DUPLICATE, tg, sq, 16'd0, 16'd0);
            end else begin
                r.dseq = trk_expected;
                trk_expected = trk_expected + {16'd0, ln - trim[15:0]};
                push_result(tsrt_pkg::KIND_DELIVER_IN, tg, r.dseq, trim[15:0],
                            ln - trim[15:0]);
                emitted = 1;
                // Release buffered slots that now line up, lowest index first
                found = 1'b1;
                while (found && emitted < 1 + tsrt_pkg::SLOTS) begin
                    found = 1'b0;
                    for (int i = 0; i < tsrt_pkg::SLOTS && !found; i++) begin
                        if (trk_valid[i] && trk_seq[i] == trk_expected) begin
                            trk_valid[i] = 1'b0;
                            trk_expected = trk_seq[i] + {16'd0, trk_len[i]};
                            push_result(tsrt_pkg::KIND_DELIVER_SLOT, trk_tag[i], trk_seq[i],
                                        16'd0, trk_len[i]);
                            emitted++;
                            found = 1'b1;
                        end
                    end
                end
            end
        end
        r = pending_results.pop_back();
        r.last = 1'b1;
        pending_results.push_back(r);
    endfunction

    // Send one segment beat and predict its results on acceptance
    task automatic send_segment(logic [31:0] sq, logic [15:0] ln, logic [15:0] tg);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        seg_seq  <= sq;
        seg_len  <= ln;
        seg_tag  <= tg;
        do @(posedge clk); while (!in_ready);
        predict_segment(sq, ln, tg);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write, only while the tracker is idle
    task automatic write_start_seq(logic [31:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 1'b0;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        restart_stream(value);
    endtask

    task automatic test_reset_state();
        send_segment(32'h0, 16'd4, 16'h0000);
        send_segment(32'h8, 16'd4, 16'hFFFF);
    endtask

    // Fill the table across the wrap, hit full and overlap, then flush a long chain
    task automatic test_slot_table();
        logic [31:0] base;
        base = 32'hFFFF_FFE0;
        write_start_seq(base);
        for (int i = 7; i >= 0; i--)
            send_segment(base + 32'(16 * (i + 1)), 16'd16, 16'(16'h0100 + i));
        send_segment(base + 32'd400, 16'd8, 16'h0200);
        send_segment(base + 32'd20, 16'd4, 16'h0201);
        send_segment(base, 16'd16, 16'h0202);
        send_segment(trk_expected, 16'd0, 16'h0203);
        send_segment(trk_expected - 32'd16, 16'd16, 16'h0204);
        send_segment(trk_expected - 32'd4, 16'd10, 16'h0205);
        send_segment(trk_expected + 32'h8000_0000, 16'd16, 16'h0206);
    endtask

    task automatic test_register_extremes();
        write_start_seq(32'hFFFF_FFFF);
        send_segment(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_segment(32'h0000_0000, 16'd1, 16'h0000);
        write_start_seq(32'h0000_0000);
        send_segment(32'h7FFF_FFFF, 16'hFFFF, 16'h5A5A);
        send_segment(32'h0000_0000, 16'd7, 16'hA5A5);
    endtask

    // Mostly near-sequence segments with random content, some noise
    task automatic test_random_stream(int items, logic [31:0] start);
        int          pick;
        logic [31:0] sq;
        logic [15:0] ln;
        write_start_seq(start);
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(0, 99);
            ln   = 16'($urandom_range(1, 48));
            if (pick < 30)
                sq = trk_expected;
            else if (pick < 75)
                sq = trk_expected + $urandom_range(1, 256);
            else if (pick < 85)
                sq = trk_expected - $urandom_range(1, 64);
            else if (pick < 90) begin
                sq = trk_expected + $urandom_range(0, 64);
                ln = 16'd0;
            end else begin
                sq = $urandom;
                ln = 16'($urandom_range(0, 65535));
            end
            send_segment(sq, ln, 16'($urandom_range(0, 65535)));
        end
    endtask

    // Take each result beat and compare it with the oldest prediction
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        seg_result_t r;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing predicted");
                fail_count++;
            end else begin
                r = pending_results.pop_front();
                check_field("result_kind", 32'(r.kind), 32'(result_kind));
                check_field("out_tag", 32'(r.tag), 32'(out_tag));
                check_field("deliver_seq", r.dseq, deliver_seq);
                check_field("trim_offset", 32'(r.trim), 32'(trim_offset));
                check_field("deliver_len", 32'(r.dlen), 32'(deliver_len));
                check_field("exp_after", r.nexp, exp_after);
                check_field("buffered_count", 32'(r.count), 32'(buffered_count));
                check_field("last", 32'(r.last), 32'(last));
            end
        end
    end

    // Result side backpressure
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Hold a limit on cycles with no beat or register access
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = 1'b0;
        pwdata      = 32'h0;
        in_valid    = 1'b0;
        seg_seq     = 32'h0;
        seg_len     = 16'h0;
        seg_tag     = 16'h0;
        no_idle     = 1'b0;
        restart_stream(32'h0);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_slot_table();
        test_register_extremes();
        test_random_stream(60, $urandom);
        test_random_stream(60, 32'hFFFF_FF00);
        no_idle = 1'b1;
        test_random_stream(60, $urandom);
        no_idle = 1'b0;
        test_random_stream(60, 32'h7FFF_FFC0);
        test_random_stream(60, $urandom);
        wait_drained();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
